### hdl/usb_control_transfer_sequencer_assert.svh
// Assertion macros for the control transfer sequencer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef USB_CONTROL_TRANSFER_SEQUENCER_ASSERT_SVH
`define USB_CONTROL_TRANSFER_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define UCTSEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define UCTSEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UCTSEQ_ASSERT_SAME(lbl, ante, cons, msg)
`define UCTSEQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/uctseq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uctseq_pkg;

  // Largest piece a data stage moves per packet.
  localparam int PACKET_BYTES = 8;
  // Byte lanes that travel in out_bytes.
  localparam int NUM_LANES = 8;
  localparam int PIECE_W = $clog2(PACKET_BYTES + 1);
  localparam int ID_BYTES = 4;
  localparam logic [7:0] OTHER_SPEED_BYTE = 8'h07;

  typedef enum logic [2:0] {
    OP_SETUP      = 3'd0,
    OP_DATA_OUT   = 3'd1,
    OP_DATA_IN    = 3'd2,
    OP_STATUS     = 3'd3,
    OP_BUS_RESET  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SETUP  = 3'd1,
    ST_DIN    = 3'd2,
    ST_DOUT   = 3'd3,
    ST_STATUS = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    HS_NONE         = 3'd0,
    HS_ARM          = 3'd1,
    HS_STALL        = 3'd2,
    HS_STATUS_ACK   = 3'd3,
    HS_STATUS_STALL = 3'd4
  } hs_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        device_to_host;
    logic [15:0] requested_length;
    logic        request_accepted;
    logic [15:0] reply_length;
    logic        patch_other_speed;
    logic        patch_ids;
    logic [63:0] packet_bytes;
  } event_t;

  typedef struct packed {
    logic [2:0]  handshake;
    logic [2:0]  next_stage;
    logic [15:0] phase_length;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic [15:0] buffer_offset;
    logic        stage_done;
  } result_t;

  // Per-packet controls shared by all byte lanes.
  typedef struct packed {
    logic               move;
    logic               is_din;
    logic [PIECE_W-1:0] piece_len;
    logic               ids_hit;
    logic               speed_hit;
  } lane_ctrl_t;

endpackage

`default_nettype wire

### hdl/uctseq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface uctseq_event_if;
  import uctseq_pkg::*;
  logic   valid;
  logic   ready;
  event_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface uctseq_result_if;
  import uctseq_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface uctseq_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/uctseq_byte_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module uctseq_byte_lane #(
  parameter int LANE = 0
) (
  input  uctseq_pkg::lane_ctrl_t lc,
  input  logic [7:0]             data_byte,
  input  logic [7:0]             id_byte,
  output logic [7:0]             out_byte
);
  import uctseq_pkg::*;

  localparam logic [PIECE_W-1:0] LANE_POS = PIECE_W'(LANE);
  localparam logic IS_ID_LANE = (LANE < ID_BYTES);
  localparam logic IS_SPEED_LANE = (LANE == 1);

  always_comb begin
    priority if (!lc.move || (lc.piece_len <= LANE_POS)) begin
      out_byte = 8'h00;
    end else if (lc.is_din && lc.ids_hit && IS_ID_LANE) begin
      out_byte = id_byte;
    end else if (lc.is_din && lc.speed_hit && IS_SPEED_LANE) begin
      out_byte = OTHER_SPEED_BYTE;
    end else begin
      out_byte = data_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/uctseq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module uctseq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  uctseq_pkg::event_t     ev,
  output uctseq_pkg::lane_ctrl_t lc,
  output uctseq_pkg::result_t    core
);
  import uctseq_pkg::*;

  localparam logic [15:0] PIECE_MAX = 16'(PACKET_BYTES);

  stage_t      stage, stage_next;
  logic        stall_pending, stall_pending_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [1:0]  round_count, round_count_next;
  logic [1:0]  patch_flags, patch_flags_next;

  logic               move;
  logic [PIECE_W-1:0] piece;
  logic [15:0]        clamp;
  logic [15:0]        left_after;

  assign piece = (bytes_left > PIECE_MAX) ? PIECE_W'(PACKET_BYTES)
                                          : bytes_left[PIECE_W-1:0];
  assign clamp = (ev.requested_length < ev.reply_length) ? ev.requested_length
                                                         : ev.reply_length;
  assign left_after = bytes_left - 16'(piece);

  always_comb begin
    stage_next         = stage;
    stall_pending_next = stall_pending;
    bytes_left_next    = bytes_left;
    byte_offset_next   = byte_offset;
    round_count_next   = round_count;
    patch_flags_next   = patch_flags;
    move               = 1'b0;
    core               = '0;

    unique case (ev.opcode)
      OP_SETUP: begin
        patch_flags_next = {ev.patch_ids, ev.patch_other_speed};
        round_count_next = 2'd0;
        byte_offset_next = 16'd0;
        if (ev.request_accepted) begin
          stall_pending_next = 1'b0;
          bytes_left_next    = clamp;
          core.phase_length  = clamp;
          core.handshake     = HS_ARM;
          if (clamp == 16'd0) begin
            stage_next = ST_STATUS;
          end else if (ev.device_to_host) begin
            stage_next = ST_DIN;
          end else begin
            stage_next = ST_DOUT;
          end
        end else begin
          bytes_left_next = 16'd0;
          core.handshake  = HS_STALL;
          stage_next      = ST_IDLE;
        end
      end
      OP_DATA_OUT: move = (stage == ST_DOUT);
      OP_DATA_IN:  move = (stage == ST_DIN);
      OP_STATUS: begin
        if (stage == ST_STATUS) begin
          core.handshake = stall_pending ? HS_STATUS_STALL : HS_STATUS_ACK;
          stage_next     = ST_IDLE;
        end
      end
      OP_BUS_RESET: stage_next = ST_IDLE;
      default: ;
    endcase

    if (move) begin
      core.handshake     = HS_ARM;
      core.buffer_offset = byte_offset;
      core.byte_count    = (piece > PIECE_W'(15)) ? 4'd15 : 4'(piece);
      bytes_left_next    = left_after;
      byte_offset_next   = byte_offset + 16'(piece);
      if ((ev.opcode == OP_DATA_IN) && (round_count < 2'd2)) begin
        round_count_next = round_count + 2'd1;
      end
      if (left_after == 16'd0) begin
        stall_pending_next = (ev.opcode == OP_DATA_OUT) ? !ev.request_accepted : 1'b0;
        stage_next         = ST_STATUS;
        core.stage_done    = 1'b1;
      end
    end

    core.next_stage = stage_next;
  end

  assign lc.move      = move;
  assign lc.is_din    = (ev.opcode == OP_DATA_IN);
  assign lc.piece_len = piece;
  assign lc.ids_hit   = patch_flags[1] && (round_count == 2'd1);
  assign lc.speed_hit = patch_flags[0] && (round_count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ST_IDLE;
      stall_pending <= 1'b0;
      bytes_left    <= 16'd0;
      byte_offset   <= 16'd0;
      round_count   <= 2'd0;
      patch_flags   <= 2'd0;
    end else if (accept) begin
      stage         <= stage_next;
      stall_pending <= stall_pending_next;
      bytes_left    <= bytes_left_next;
      byte_offset   <= byte_offset_next;
      round_count   <= round_count_next;
      patch_flags   <= patch_flags_next;
    end
  end

endmodule

`default_nettype wire

### hdl/usb_control_transfer_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "usb_control_transfer_sequencer_assert.svh"
// Channel     Role   Carries
// ---------   ----   ---------------------------------------------------
// bus_event   sink   one bus event request: opcode, setup fields, 8 bytes
// result      source one result per event: handshake, stage, data piece
// cfg         sink   vendor/product id write, always ready
//
// One event request is taken every cycle while the skid entry is empty; its
// result is registered, in the result register or in the skid entry. The stage
// registers and the eight byte lanes settle within the accepting cycle.
// A two-entry output buffer (result register plus skid) holds results while
// result.ready is low; bus_event.ready drops only when both entries are full.
// Synchronous active-high reset clears the stage state, the id register and
// both buffer entries.
module usb_control_transfer_sequencer (
  input logic           clk,
  input logic           rst,
  uctseq_event_if.sink  bus_event,
  uctseq_result_if.source result,
  uctseq_cfg_if.sink    cfg
);
  import uctseq_pkg::*;

  logic [31:0] vendor_product_id;
  lane_ctrl_t  lc;
  result_t     core;
  result_t     merged;
  logic [63:0] lane_bytes;
  logic        in_accept;
  logic        out_take;

  result_t     res_data;
  logic        res_valid;
  result_t     skid_data;
  logic        skid_valid;

  // Config writes always taken; send only while block idle, not enforced.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_product_id <= 32'd0;
    end else if (cfg.valid) begin
      vendor_product_id <= cfg.data;
    end
  end

  assign bus_event.ready = !skid_valid;
  assign in_accept = bus_event.valid && bus_event.ready;
  assign out_take  = res_valid && result.ready;

  // Stage machine: decides the handshake, next stage and piece controls.
  uctseq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .ev     (bus_event.payload),
    .lc     (lc),
    .core   (core)
  );

  // Byte lanes: mask, id patch and other-speed patch, one byte each.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic [7:0] id_byte;
    if (i < ID_BYTES) begin : g_id
      assign id_byte = vendor_product_id[8*i +: 8];
    end else begin : g_no_id
      assign id_byte = 8'h00;
    end
    uctseq_byte_lane #(
      .LANE (i)
    ) u_lane (
      .lc        (lc),
      .data_byte (bus_event.payload.packet_bytes[8*i +: 8]),
      .id_byte   (id_byte),
      .out_byte  (lane_bytes[8*i +: 8])
    );
  end

  // Merge: drop the lane bytes into the stage machine's result.
  always_comb begin
    merged           = core;
    merged.out_bytes = lane_bytes;
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        if (!res_valid || result.ready) begin
          res_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          res_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!res_valid || result.ready) begin
        res_data <= merged;
      end else begin
        skid_data <= merged;
      end
    end else if (out_take && skid_valid) begin
      res_data <= skid_data;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_data;

  `UCTSEQ_ASSERT_SAME(a_skid_behind_res, skid_valid, res_valid, "skid full with empty result register")
  `UCTSEQ_ASSERT_NEXT(a_stall_fills_skid, in_accept && res_valid && !result.ready, skid_valid, "held result lost an incoming request")
  `UCTSEQ_ASSERT_SAME(a_piece_arms, result.valid && (result.payload.byte_count != 4'd0), result.payload.handshake == HS_ARM, "data piece without arm handshake")
  `UCTSEQ_ASSERT_SAME(a_done_to_status, result.valid && result.payload.stage_done, result.payload.next_stage == ST_STATUS, "finished data stage not moving to status")

endmodule

`default_nettype wire
